@@ hdl/tun_pkg.sv @@
// Shared package for the triangle unit-normal pipeline.
// Holds the default parameters, the output width and the per-stage control struct.
// No dependencies.
package tun_pkg;

    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int OUT_WIDTH            = 16;

    // travels alongside every item through the cell chain
    typedef struct packed {
        logic valid;
        logic zero;     // cross product is the zero vector
    } tun_ctl_t;

endpackage

@@ hdl/tun_front.sv @@
// Front pipeline: edge vectors, cross product, magnitudes and the sum of squares.
// Six register stages; depends on tun_pkg.
module tun_front
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] pt [9],
    output tun_ctl_t                      ctl_out,
    output logic [4*COORD_WIDTH+5:0]      sum_out,
    output logic [2*COORD_WIDTH+1:0]      mag_out [3],
    output logic                          neg_out [3]
);

    localparam int EW = COORD_WIDTH + 1;      // edge
    localparam int PW = 2 * EW;               // edge product
    localparam int CW = PW + 1;               // cross component
    localparam int MW = PW;                   // cross magnitude
    localparam int HW = (MW + 1) / 2;         // half of a magnitude
    localparam int SW = 2 * MW + 2;           // sum of squares

    logic [5:0]               v_reg;

    logic signed [EW-1:0]     a_reg [3];
    logic signed [EW-1:0]     b_reg [3];
    logic signed [PW-1:0]     pr_reg [6];
    logic [MW-1:0]            m3_reg [3];
    logic [MW-1:0]            m4_reg [3];
    logic [MW-1:0]            m5_reg [3];
    logic [MW-1:0]            m6_reg [3];
    logic                     n3_reg [3];
    logic                     n4_reg [3];
    logic                     n5_reg [3];
    logic                     n6_reg [3];
    logic [2*HW-1:0]          hh_reg [3];
    logic [2*HW-1:0]          hl_reg [3];
    logic [2*HW-1:0]          ll_reg [3];
    logic [2*MW-1:0]          sq_reg [3];
    logic [SW-1:0]            sum_reg;
    logic                     zero_reg;

    logic signed [CW-1:0]     c_next [3];
    logic [MW-1:0]            m_next [3];
    logic [2*HW-1:0]          mp     [3];
    logic [4*HW-1:0]          sq_next [3];
    logic [SW-1:0]            sum_next;

    always_comb
    begin
        c_next[0] = CW'(pr_reg[0]) - CW'(pr_reg[1]);
        c_next[1] = CW'(pr_reg[2]) - CW'(pr_reg[3]);
        c_next[2] = CW'(pr_reg[4]) - CW'(pr_reg[5]);
        for (int i = 0; i < 3; i++)
        begin
            m_next[i]  = c_next[i][CW-1] ? MW'(-c_next[i]) : MW'(c_next[i]);
            mp[i]      = (2*HW)'(m3_reg[i]);
            sq_next[i] = {hh_reg[i], {(2*HW){1'b0}}}
                       + ((4*HW)'(hl_reg[i]) << (HW + 1))
                       + (4*HW)'(ll_reg[i]);
        end
        sum_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i] <= EW'(pt[i]) - EW'(pt[3+i]);
                b_reg[i] <= EW'(pt[3+i]) - EW'(pt[6+i]);
            end
            pr_reg[0] <= PW'(a_reg[1]) * PW'(b_reg[2]);
            pr_reg[1] <= PW'(a_reg[2]) * PW'(b_reg[1]);
            pr_reg[2] <= PW'(a_reg[2]) * PW'(b_reg[0]);
            pr_reg[3] <= PW'(a_reg[0]) * PW'(b_reg[2]);
            pr_reg[4] <= PW'(a_reg[0]) * PW'(b_reg[1]);
            pr_reg[5] <= PW'(a_reg[1]) * PW'(b_reg[0]);
            for (int i = 0; i < 3; i++)
            begin
                m3_reg[i] <= m_next[i];
                n3_reg[i] <= c_next[i][CW-1];
                // square split into half-width products
                hh_reg[i] <= mp[i][2*HW-1:HW] * mp[i][2*HW-1:HW];
                hl_reg[i] <= mp[i][2*HW-1:HW] * mp[i][HW-1:0];
                ll_reg[i] <= mp[i][HW-1:0] * mp[i][HW-1:0];
                m4_reg[i] <= m3_reg[i];
                n4_reg[i] <= n3_reg[i];
                sq_reg[i] <= sq_next[i][2*MW-1:0];
                m5_reg[i] <= m4_reg[i];
                n5_reg[i] <= n4_reg[i];
                m6_reg[i] <= m5_reg[i];
                n6_reg[i] <= n5_reg[i];
            end
            sum_reg  <= sum_next;
            zero_reg <= (sum_next == '0);
        end
    end

    assign ctl_out.valid = v_reg[5];
    assign ctl_out.zero  = zero_reg;
    assign sum_out       = sum_reg;
    assign mag_out       = m6_reg;
    assign neg_out       = n6_reg;

endmodule

@@ hdl/tun_sqrt_cell.sv @@
// One root digit of the integer square root chain; carries the item alongside.
// Depends on tun_pkg.
module tun_sqrt_cell
    import tun_pkg::*;
#(
    parameter int SW = 70,
    parameter int RW = 35,
    parameter int MW = 34
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  tun_ctl_t         ctl_in,
    input  logic [SW-1:0]    op_in,
    input  logic [RW-1:0]    root_in,
    input  logic [RW+1:0]    rem_in,
    input  logic [MW-1:0]    mag_in [3],
    input  logic             neg_in [3],
    output tun_ctl_t         ctl_out,
    output logic [SW-1:0]    op_out,
    output logic [RW-1:0]    root_out,
    output logic [RW+1:0]    rem_out,
    output logic [MW-1:0]    mag_out [3],
    output logic             neg_out [3]
);

    tun_ctl_t          ctl_reg;
    logic [SW-1:0]     op_reg;
    logic [RW-1:0]     root_reg;
    logic [RW+1:0]     rem_reg;
    logic [MW-1:0]     mag_reg [3];
    logic              neg_reg [3];

    logic [RW+3:0]     rem2;
    logic [RW+3:0]     trial;
    logic              ge;

    // bring down two operand bits, try root*4+1
    always_comb
    begin
        rem2  = {rem_in, op_in[SW-1 -: 2]};
        trial = {2'b00, root_in, 2'b01};
        ge    = (rem2 >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg   <= op_in << 2;
            root_reg <= {root_in[RW-2:0], ge};
            rem_reg  <= ge ? (RW+2)'(rem2 - trial) : (RW+2)'(rem2);
            mag_reg  <= mag_in;
            neg_reg  <= neg_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign op_out   = op_reg;
    assign root_out = root_reg;
    assign rem_out  = rem_reg;
    assign mag_out  = mag_reg;
    assign neg_out  = neg_reg;

endmodule

@@ hdl/tun_div_cell.sv @@
// One quotient bit of the three-lane restoring divider (magnitude * 2^F / length).
// Depends on tun_pkg.
module tun_div_cell
    import tun_pkg::*;
#(
    parameter int RW = 35,
    parameter int QW = 15
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  tun_ctl_t         ctl_in,
    input  logic [RW-1:0]    len_in,
    input  logic [RW:0]      rem_in [3],
    input  logic [QW-1:0]    q_in   [3],
    input  logic             neg_in [3],
    output tun_ctl_t         ctl_out,
    output logic [RW-1:0]    len_out,
    output logic [RW:0]      rem_out [3],
    output logic [QW-1:0]    q_out   [3],
    output logic             neg_out [3]
);

    tun_ctl_t          ctl_reg;
    logic [RW-1:0]     len_reg;
    logic [RW:0]       rem_reg [3];
    logic [QW-1:0]     q_reg   [3];
    logic              neg_reg [3];

    logic              ge  [3];
    logic [RW:0]       sub [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ge[i]  = (rem_in[i] >= {1'b0, len_in});
            sub[i] = ge[i] ? (rem_in[i] - {1'b0, len_in}) : rem_in[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg <= len_in;
            for (int i = 0; i < 3; i++)
            begin
                // remainder stays below the length, so the doubled value fits
                rem_reg[i] <= {sub[i][RW-1:0], 1'b0};
                q_reg[i]   <= {q_in[i][QW-2:0], ge[i]};
            end
            neg_reg <= neg_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign len_out = len_reg;
    assign rem_out = rem_reg;
    assign q_out   = q_reg;
    assign neg_out = neg_reg;

endmodule

@@ hdl/triangle_unit_normal_unit.sv @@
// Top level: triangle face unit normal, signed Q1.14 from Q8.8 vertices.
// Uses tun_pkg, tun_front, tun_sqrt_cell, tun_div_cell.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_ready, p0_x .. p2_z         | into block
//   out     | out_valid, out_ready, normal_x/y/z,      | out of block
//           | degenerate                               |
//
// One item per clock while the chain moves. The path runs through the front stages,
// one square-root cell per root bit, one divider cell per quotient bit and the output register.
// Reset clears only the control bits of the cells, the front valid bits and the output valid bit.
// The chain moves while the output register is free or the last cell is empty,
// so items keep entering while a finished result waits.
module triangle_unit_normal_unit
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] p0_x,
    input  logic signed [COORD_WIDTH-1:0] p0_y,
    input  logic signed [COORD_WIDTH-1:0] p0_z,
    input  logic signed [COORD_WIDTH-1:0] p1_x,
    input  logic signed [COORD_WIDTH-1:0] p1_y,
    input  logic signed [COORD_WIDTH-1:0] p1_z,
    input  logic signed [COORD_WIDTH-1:0] p2_x,
    input  logic signed [COORD_WIDTH-1:0] p2_y,
    input  logic signed [COORD_WIDTH-1:0] p2_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [OUT_WIDTH-1:0]   normal_x,
    output logic signed [OUT_WIDTH-1:0]   normal_y,
    output logic signed [OUT_WIDTH-1:0]   normal_z,
    output logic                          degenerate
);

    localparam int MW = 2 * COORD_WIDTH + 2;  // cross magnitude
    localparam int SW = 2 * MW + 2;           // sum of squares
    localparam int RW = MW + 1;               // root bits
    localparam int QW = NORMAL_FRAC_BITS + 1; // quotient bits
    localparam int NW = (QW + 1 > OUT_WIDTH) ? QW + 1 : OUT_WIDTH;

    logic                          en;
    logic                          out_free;
    logic signed [COORD_WIDTH-1:0] pt [9];

    tun_ctl_t        s_ctl  [RW+1];
    logic [SW-1:0]   s_op   [RW+1];
    logic [RW-1:0]   s_root [RW+1];
    logic [RW+1:0]   s_rem  [RW+1];
    logic [MW-1:0]   s_mag  [RW+1][3];
    logic            s_neg  [RW+1][3];

    tun_ctl_t        d_ctl  [QW+1];
    logic [RW-1:0]   d_len  [QW+1];
    logic [RW:0]     d_rem  [QW+1][3];
    logic [QW-1:0]   d_q    [QW+1][3];
    logic            d_neg  [QW+1][3];

    logic                         ov_reg;
    logic signed [OUT_WIDTH-1:0]  nrm_reg  [3];
    logic                         deg_reg;
    logic signed [OUT_WIDTH-1:0]  nrm_next [3];
    logic [NW-1:0]                qx;
    logic [NW-1:0]                sval;

    assign pt = '{p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z};

    assign out_free = !ov_reg || out_ready;
    assign en       = out_free || !d_ctl[QW].valid;
    assign in_ready = en;

    tun_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .pt       (pt),
        .ctl_out  (s_ctl[0]),
        .sum_out  (s_op[0]),
        .mag_out  (s_mag[0]),
        .neg_out  (s_neg[0])
    );

    assign s_root[0] = '0;
    assign s_rem[0]  = '0;

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        tun_sqrt_cell #(
            .SW (SW),
            .RW (RW),
            .MW (MW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (s_ctl[k]),
            .op_in    (s_op[k]),
            .root_in  (s_root[k]),
            .rem_in   (s_rem[k]),
            .mag_in   (s_mag[k]),
            .neg_in   (s_neg[k]),
            .ctl_out  (s_ctl[k+1]),
            .op_out   (s_op[k+1]),
            .root_out (s_root[k+1]),
            .rem_out  (s_rem[k+1]),
            .mag_out  (s_mag[k+1]),
            .neg_out  (s_neg[k+1])
        );
    end

    assign d_ctl[0] = s_ctl[RW];
    assign d_len[0] = s_root[RW];
    assign d_neg[0] = s_neg[RW];

    // magnitude never exceeds the length, so the first bit starts unshifted
    for (genvar i = 0; i < 3; i++)
    begin : g_div_in
        assign d_rem[0][i] = (RW+1)'(s_mag[RW][i]);
        assign d_q[0][i]   = '0;
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        tun_div_cell #(
            .RW (RW),
            .QW (QW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (d_ctl[k]),
            .len_in  (d_len[k]),
            .rem_in  (d_rem[k]),
            .q_in    (d_q[k]),
            .neg_in  (d_neg[k]),
            .ctl_out (d_ctl[k+1]),
            .len_out (d_len[k+1]),
            .rem_out (d_rem[k+1]),
            .q_out   (d_q[k+1]),
            .neg_out (d_neg[k+1])
        );
    end

    always_comb
    begin
        qx   = '0;
        sval = '0;
        for (int i = 0; i < 3; i++)
        begin
            qx   = NW'(d_q[QW][i]);
            sval = d_neg[QW][i] ? (NW'(0) - qx) : qx;
            nrm_next[i] = d_ctl[QW].zero ? '0 : sval[OUT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (out_free)
        begin
            ov_reg <= d_ctl[QW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            nrm_reg <= nrm_next;
            deg_reg <= d_ctl[QW].zero;
        end
    end

    assign out_valid  = ov_reg;
    assign normal_x   = nrm_reg[0];
    assign normal_y   = nrm_reg[1];
    assign normal_z   = nrm_reg[2];
    assign degenerate = deg_reg;

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
        else $error("degenerate item with nonzero normal");

    a_nondeg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !degenerate) |->
            (normal_x != '0 || normal_y != '0 || normal_z != '0))
        else $error("regular item with all-zero normal");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with output register empty");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(degenerate)))
        else $error("waiting result lost or changed");

endmodule

@@ dv/triangle_unit_normal_unit_tb.sv @@
// Testbench for triangle_unit_normal_unit: directed table, then random triangles.
// Results are checked against an in-bench unit-normal predictor; depends on tun_pkg.
`timescale 1ns / 1ps

module triangle_unit_normal_unit_tb;
    import tun_pkg::*;

    localparam int CW        = COORD_WIDTH_DEF;
    localparam int FRAC      = NORMAL_FRAC_BITS_DEF;
    localparam int LATENCY   = 6 + (2 * CW + 3) + (FRAC + 1) + 1;
    localparam int N_RANDOM  = 800;
    localparam int WDOG_MAX  = 20000;

    typedef logic signed [CW-1:0] coord_t;
    typedef coord_t tri_t [9];

    typedef struct {
        logic signed [OUT_WIDTH-1:0] nx;
        logic signed [OUT_WIDTH-1:0] ny;
        logic signed [OUT_WIDTH-1:0] nz;
        logic                        degen;
    } normal_t;

    typedef struct {
        tri_t    verts;
        bit      has_fixed;
        normal_t fixed;
    } vec_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    coord_t p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
    logic out_valid;
    logic out_ready;
    logic signed [OUT_WIDTH-1:0] normal_x, normal_y, normal_z;
    logic degenerate;

    normal_t pending_normals[$];
    vec_row_t vec_table[$];
    int  mismatches;
    int  wdog;
    bit  timed_out;
    bit  send_done;

    triangle_unit_normal_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
        .p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
        .p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .degenerate(degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] root_floor(logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  cand;
        logic [127:0] sq;
        r = '0;
        for (int b = 55; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            sq = {64'd0, cand} * {64'd0, cand};
            if (sq <= s)
                r = cand;
        end
        return r;
    endfunction

    function automatic normal_t face_normal(tri_t v);
        normal_t res;
        longint  e1[3], e2[3], c[3];
        logic [127:0] sum, m;
        logic [63:0]  len;
        logic [127:0] q;
        logic [OUT_WIDTH-1:0] comp[3];
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = longint'(v[i]) - longint'(v[3 + i]);
            e2[i] = longint'(v[3 + i]) - longint'(v[6 + i]);
        end
        c[0] = e1[1] * e2[2] - e1[2] * e2[1];
        c[1] = e1[2] * e2[0] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e1[1] * e2[0];
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            m = (c[i] < 0) ? 128'(-c[i]) : 128'(c[i]);
            sum += m * m;
        end
        if (sum == 0)
        begin
            res.nx = '0; res.ny = '0; res.nz = '0; res.degen = 1'b1;
            return res;
        end
        len = root_floor(sum);
        for (int i = 0; i < 3; i++)
        begin
            m = (c[i] < 0) ? 128'(-c[i]) : 128'(c[i]);
            q = (m << FRAC) / {64'd0, len};
            if (q > (128'd1 << FRAC))
                q = 128'd1 << FRAC;
            if (c[i] < 0)
                q = -q;
            comp[i] = q[OUT_WIDTH-1:0];
        end
        res.nx = comp[0]; res.ny = comp[1]; res.nz = comp[2]; res.degen = 1'b0;
        return res;
    endfunction

    task automatic add_row(tri_t v, bit has_fixed, normal_t fixed);
        vec_row_t r;
        r.verts = v; r.has_fixed = has_fixed; r.fixed = fixed;
        vec_table = {vec_table, r};
    endtask

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_triangle(tri_t v, normal_t exp_n);
        int gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        p0_x <= v[0]; p0_y <= v[1]; p0_z <= v[2];
        p1_x <= v[3]; p1_y <= v[4]; p1_z <= v[5];
        p2_x <= v[6]; p2_y <= v[7]; p2_z <= v[8];
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_normals = {pending_normals, exp_n};
        @(negedge clk);
    endtask

    function automatic coord_t rand_coord(int spread);
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom);
            1: return coord_t'(16'sh7fff);
            2: return coord_t'(16'sh8000);
            default: return coord_t'($urandom_range(0, 2 * spread) - spread);
        endcase
    endfunction

    // stimulus
    initial
    begin
        tri_t v;
        normal_t n, none;
        int spread;
        none = '{default: '0};
        rst_n = 1'b0;
        in_valid = 1'b0;
        {p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z} = '0;
        send_done = 1'b0;

        // all-zero and coincident vertices: degenerate
        add_row('{default: coord_t'(0)}, 1, '{16'sd0, 16'sd0, 16'sd0, 1'b1});
        add_row('{default: coord_t'(16'sh7fff)}, 1, '{16'sd0, 16'sd0, 16'sd0, 1'b1});
        // collinear
        add_row('{0, 0, 0, 256, 256, 256, 512, 512, 512}, 1,
                '{16'sd0, 16'sd0, 16'sd0, 1'b1});
        // axis-aligned triangles give exact unit normals
        add_row('{0, 0, 0, 256, 0, 0, 256, 256, 0}, 1, '{16'sd0, 16'sd0, 16'sd16384, 1'b0});
        add_row('{0, 0, 0, 256, 256, 0, 256, 0, 0}, 1, '{16'sd0, 16'sd0, -16'sd16384, 1'b0});
        add_row('{0, 0, 0, 0, 256, 0, 0, 256, 256}, 1, '{16'sd16384, 16'sd0, 16'sd0, 1'b0});
        add_row('{0, 0, 0, 0, 0, 256, 256, 0, 256}, 1, '{16'sd0, 16'sd16384, 16'sd0, 1'b0});
        // extremes of the coordinate range, and small triangles
        add_row('{-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767}, 0, none);
        add_row('{32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768}, 0, none);
        add_row('{-32768, 0, 0, 32767, 0, 0, 0, 32767, 0}, 0, none);
        add_row('{0, 0, 32767, 0, -32768, 0, -32768, 0, 0}, 0, none);
        add_row('{1, 0, 0, 0, 1, 0, 0, 0, 1}, 0, none);
        add_row('{-1, -1, -1, 1, -1, 1, -1, 1, 1}, 0, none);
        add_row('{-32768, -32768, -32768, -32767, -32768, -32768, -32768, -32767, -32768},
                0, none);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (vec_table[i])
        begin
            n = vec_table[i].has_fixed ? vec_table[i].fixed : face_normal(vec_table[i].verts);
            send_triangle(vec_table[i].verts, n);
        end

        for (int k = 0; k < N_RANDOM; k++)
        begin
            // drain once mid-run
            if (k == N_RANDOM / 2)
            begin
                in_valid <= 1'b0;
                wait (pending_normals.size() == 0);
                @(negedge clk);
            end
            spread = ($urandom_range(0, 1) == 0) ? 32767 : $urandom_range(1, 512);
            foreach (v[j])
                v[j] = rand_coord(spread);
            if ($urandom_range(0, 15) == 0)
            begin
                // collinear or repeated vertex
                for (int j = 0; j < 3; j++)
                    v[6 + j] = v[3 + j];
            end
            send_triangle(v, face_normal(v));
        end
        in_valid <= 1'b0;
        send_done = 1'b1;
    end

    // result sink
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // compare results
    always @(posedge clk)
    begin
        normal_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_normals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d %0d %0d deg=%0d",
                             normal_x, normal_y, normal_z, degenerate);
            end
            else
            begin
                e = pending_normals.pop_front();
                if (normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz ||
                    degenerate !== e.degen)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d deg=%0d, got %0d %0d %0d deg=%0d",
                                 e.nx, e.ny, e.nz, e.degen,
                                 normal_x, normal_y, normal_z, degenerate);
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
    end

    initial
    begin
        timed_out = 1'b0;
        @(posedge rst_n);
        fork
            begin
                wait (send_done && pending_normals.size() == 0);
                repeat (LATENCY + 20) @(posedge clk);
            end
            begin
                wait (wdog >= WDOG_MAX);
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && mismatches == 0 && pending_normals.size() == 0)
            $display("triangle_unit_normal_unit verification clean");
        else
            $display("triangle_unit_normal_unit verification failed");
        $finish;
    end

endmodule
